// ===== rtl/core/ckrm_pkg.sv =====
// Package for the color key region measure core: frame bounds, field widths,
// configuration register codes and the pixel control struct.
// Used by every module of the core; depends on nothing.
package ckrm_pkg;

	localparam int MAX_COLS = 2048;
	localparam int MAX_ROWS = 2048;

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	localparam int CHAN_W = 8;
	localparam int CNT_W  = 12;
	localparam int POS_W  = 11;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_RED   = 2'd0,
		CFG_KEY_GREEN = 2'd1,
		CFG_KEY_BLUE  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic hit;
		logic row_end;
		logic frame_end;
	} pix_ctl_t;

endpackage

// ===== rtl/core/ckrm_in_stage.sv =====
// Input stage: key color registers, exact color compare and the input
// pipeline register. Depends on ckrm_pkg.
module ckrm_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ckrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ckrm_pkg::CHAN_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ckrm_pkg::CHAN_W-1:0]    pix_blue,
	input  logic [ckrm_pkg::CHAN_W-1:0]    pix_green,
	input  logic [ckrm_pkg::CHAN_W-1:0]    pix_red,
	input  logic                           row_end,
	input  logic                           frame_end,
	input  logic                           advance,
	output logic                           valid_s1,
	output ckrm_pkg::pix_ctl_t             ctl_s1
);

	logic [ckrm_pkg::CHAN_W-1:0] key_red_q;
	logic [ckrm_pkg::CHAN_W-1:0] key_green_q;
	logic [ckrm_pkg::CHAN_W-1:0] key_blue_q;
	logic                        in_fire;
	ckrm_pkg::pix_ctl_t          ctl_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;

	assign ctl_d.hit = (pix_red == key_red_q) && (pix_green == key_green_q) &&
		(pix_blue == key_blue_q);
	assign ctl_d.row_end   = row_end;
	assign ctl_d.frame_end = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_red_q   <= '0;
			key_green_q <= '0;
			key_blue_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ckrm_pkg::CFG_KEY_RED:   key_red_q   <= cfg_data;
				ckrm_pkg::CFG_KEY_GREEN: key_green_q <= cfg_data;
				ckrm_pkg::CFG_KEY_BLUE:  key_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1 <= ctl_d;
		end
	end

endmodule

// ===== rtl/core/ckrm_accum.sv =====
// Frame accumulator: position counters, row and run tracking, and the result
// register that holds one frame summary. Depends on ckrm_pkg.
module ckrm_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  ckrm_pkg::pix_ctl_t          ctl_s1,
	output logic                        advance,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ckrm_pkg::CNT_W-1:0]  last_row_matches,
	output logic [ckrm_pkg::CNT_W-1:0]  rows_matched,
	output logic [ckrm_pkg::POS_W-1:0]  run_left_col,
	output logic [ckrm_pkg::POS_W-1:0]  run_top_row,
	output logic                        any_found
);

	localparam logic [ckrm_pkg::COL_W-1:0] ColLast = ckrm_pkg::COL_W'(ckrm_pkg::MAX_COLS - 1);
	localparam logic [ckrm_pkg::ROW_W-1:0] RowLast = ckrm_pkg::ROW_W'(ckrm_pkg::MAX_ROWS - 1);
	localparam logic [ckrm_pkg::CNT_W-1:0] CntMax  = '1;

	logic [ckrm_pkg::COL_W-1:0] col_q,       col_d;
	logic [ckrm_pkg::ROW_W-1:0] row_q,       row_d;
	logic                       prev_hit_q,  prev_hit_d;
	logic [ckrm_pkg::CNT_W-1:0] row_cnt_q,   row_cnt_d;
	logic [ckrm_pkg::CNT_W-1:0] total_q,     total_d;
	logic [ckrm_pkg::CNT_W-1:0] kept_q,      kept_d;
	logic [ckrm_pkg::COL_W-1:0] start_col_q, start_col_d;
	logic [ckrm_pkg::ROW_W-1:0] start_row_q, start_row_d;
	logic [ckrm_pkg::CNT_W-1:0] row_cnt_inc;
	logic                       line_end;

	assign advance  = valid_s1 && (!ctl_s1.frame_end || !out_valid || out_ready);
	assign line_end = ctl_s1.row_end || ctl_s1.frame_end;

	always_comb begin
		start_col_d = start_col_q;
		start_row_d = start_row_q;
		if (ctl_s1.hit && (col_q == '0 || !prev_hit_q)) begin
			start_col_d = col_q;
			start_row_d = row_q;
		end
		row_cnt_inc = (ctl_s1.hit && row_cnt_q != CntMax) ? row_cnt_q + 1'b1 : row_cnt_q;
		total_d     = total_q;
		kept_d      = kept_q;
		if (line_end) begin
			if (row_cnt_inc != '0) begin
				total_d = (total_q != CntMax) ? total_q + 1'b1 : total_q;
				kept_d  = row_cnt_inc;
			end
			row_cnt_d  = '0;
			col_d      = '0;
			prev_hit_d = 1'b0;
			row_d      = (row_q < RowLast) ? row_q + 1'b1 : row_q;
		end else begin
			row_cnt_d  = row_cnt_inc;
			prev_hit_d = ctl_s1.hit;
			row_d      = row_q;
			col_d      = (col_q < ColLast) ? col_q + 1'b1 : col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			prev_hit_q  <= 1'b0;
			row_cnt_q   <= '0;
			total_q     <= '0;
			kept_q      <= '0;
			start_col_q <= '0;
			start_row_q <= '0;
		end else if (advance) begin
			if (ctl_s1.frame_end) begin
				col_q       <= '0;
				row_q       <= '0;
				prev_hit_q  <= 1'b0;
				row_cnt_q   <= '0;
				total_q     <= '0;
				kept_q      <= '0;
				start_col_q <= '0;
				start_row_q <= '0;
			end else begin
				col_q       <= col_d;
				row_q       <= row_d;
				prev_hit_q  <= prev_hit_d;
				row_cnt_q   <= row_cnt_d;
				total_q     <= total_d;
				kept_q      <= kept_d;
				start_col_q <= start_col_d;
				start_row_q <= start_row_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && ctl_s1.frame_end) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl_s1.frame_end) begin
			last_row_matches <= kept_d;
			rows_matched     <= total_d;
			run_left_col     <= ckrm_pkg::POS_W'(start_col_d);
			run_top_row      <= ckrm_pkg::POS_W'(start_row_d);
			any_found        <= (total_d != '0);
		end
	end

endmodule

// ===== rtl/core/color_key_region_measure_core.sv =====
// Top level of the color key region measure core.
// Instantiates ckrm_in_stage and ckrm_accum; depends on ckrm_pkg.
//
// Channel   Direction  Handshake              Contents
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data (key color components)
// in        in         in_valid / in_ready    pix_red/green/blue, row_end, frame_end
// out       out        out_valid / out_ready  frame summary, one per frame_end pixel
//
// One pixel request is accepted every cycle unless a held summary stalls the input; the
// per-pixel state loop in the accumulator is a single registered update, so throughput
// is one pixel per clock. A frame summary is loaded into the result register when its
// frame_end pixel leaves the input pipeline register. Reset clears the key registers,
// all counters and both valid flags. A held summary stalls the input only when the next
// frame_end pixel reaches the accumulator; ordinary pixels keep flowing past it.
module color_key_region_measure_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ckrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ckrm_pkg::CHAN_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ckrm_pkg::CHAN_W-1:0]    pix_blue,
	input  logic [ckrm_pkg::CHAN_W-1:0]    pix_green,
	input  logic [ckrm_pkg::CHAN_W-1:0]    pix_red,
	input  logic                           row_end,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ckrm_pkg::CNT_W-1:0]     last_row_matches,
	output logic [ckrm_pkg::CNT_W-1:0]     rows_matched,
	output logic [ckrm_pkg::POS_W-1:0]     run_left_col,
	output logic [ckrm_pkg::POS_W-1:0]     run_top_row,
	output logic                           any_found
);

	logic               valid_s1;
	logic               advance;
	ckrm_pkg::pix_ctl_t ctl_s1;

	ckrm_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pix_blue  (pix_blue),
		.pix_green (pix_green),
		.pix_red   (pix_red),
		.row_end   (row_end),
		.frame_end (frame_end),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1)
	);

	ckrm_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s1         (valid_s1),
		.ctl_s1           (ctl_s1),
		.advance          (advance),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.last_row_matches (last_row_matches),
		.rows_matched     (rows_matched),
		.run_left_col     (run_left_col),
		.run_top_row      (run_top_row),
		.any_found        (any_found)
	);

endmodule

// ===== rtl/core/ckrm_checker.sv =====
// Port-level checker for the color key region measure core, bound to the top.
// Depends on ckrm_pkg and color_key_region_measure_core.
module ckrm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ckrm_pkg::CNT_W-1:0] last_row_matches,
	input logic [ckrm_pkg::CNT_W-1:0] rows_matched,
	input logic [ckrm_pkg::POS_W-1:0] run_left_col,
	input logic [ckrm_pkg::POS_W-1:0] run_top_row,
	input logic                       any_found
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rows_matched) &&
		$stable(last_row_matches) && $stable(run_left_col) && $stable(run_top_row))
		else $error("stalled summary changed or dropped");

	a_found_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> any_found == (rows_matched != '0))
		else $error("any_found disagrees with rows_matched");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> any_found == (last_row_matches != '0))
		else $error("any_found disagrees with last_row_matches");

	a_empty_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !any_found |-> run_left_col == '0 && run_top_row == '0)
		else $error("empty frame reports a run start");

endmodule

bind color_key_region_measure_core ckrm_checker u_ckrm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.last_row_matches (last_row_matches),
	.rows_matched     (rows_matched),
	.run_left_col     (run_left_col),
	.run_top_row      (run_top_row),
	.any_found        (any_found)
);

// ===== sim/color_key_region_measure_core_test.sv =====
// Testbench for color_key_region_measure_core: drives pixel frames and key color writes,
// predicts each frame summary and checks it against the core's output.
// Depends on ckrm_pkg and color_key_region_measure_core.
`timescale 1ns / 100ps

module color_key_region_measure_core_test;

	localparam int CNT_MAX = (1 << ckrm_pkg::CNT_W) - 1;
	localparam int PIX_W = 3 * ckrm_pkg::CHAN_W;
	localparam int LONG_LEN = 80;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [ckrm_pkg::CNT_W-1:0] last_row_matches;
		logic [ckrm_pkg::CNT_W-1:0] rows_matched;
		logic [ckrm_pkg::POS_W-1:0] run_left_col;
		logic [ckrm_pkg::POS_W-1:0] run_top_row;
		logic                       any_found;
	} frame_summary_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	ckrm_pkg::cfg_reg_t          cfg_index = ckrm_pkg::CFG_KEY_RED;
	logic [ckrm_pkg::CHAN_W-1:0] cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [ckrm_pkg::CHAN_W-1:0] pix_blue = '0;
	logic [ckrm_pkg::CHAN_W-1:0] pix_green = '0;
	logic [ckrm_pkg::CHAN_W-1:0] pix_red = '0;
	logic                        row_end = 1'b0;
	logic                        frame_end = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [ckrm_pkg::CNT_W-1:0]  last_row_matches;
	logic [ckrm_pkg::CNT_W-1:0]  rows_matched;
	logic [ckrm_pkg::POS_W-1:0]  run_left_col;
	logic [ckrm_pkg::POS_W-1:0]  run_top_row;
	logic                        any_found;

	frame_summary_t    summary_q[$];
	int                mismatches = 0;
	int                pixels_sent = 0;
	int                frames_sent = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;

	logic [ckrm_pkg::CHAN_W-1:0] key_r = '0;
	logic [ckrm_pkg::CHAN_W-1:0] key_g = '0;
	logic [ckrm_pkg::CHAN_W-1:0] key_b = '0;
	int                cur_col = 0;
	int                cur_row = 0;
	logic              left_hit = 1'b0;
	int                row_hits = 0;
	int                hit_rows = 0;
	int                kept_hits = 0;
	int                run_col = 0;
	int                run_row = 0;

	color_key_region_measure_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pix_blue(pix_blue),
		.pix_green(pix_green),
		.pix_red(pix_red),
		.row_end(row_end),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.last_row_matches(last_row_matches),
		.rows_matched(rows_matched),
		.run_left_col(run_left_col),
		.run_top_row(run_top_row),
		.any_found(any_found)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic measure_pixel(input logic [ckrm_pkg::CHAN_W-1:0] r, g, b,
		input logic re, fe);
		logic           hit;
		frame_summary_t s;
		hit = (r == key_r) && (g == key_g) && (b == key_b);
		if (hit) begin
			if (cur_col == 0 || !left_hit) begin
				run_col = cur_col;
				run_row = cur_row;
			end
			if (row_hits < CNT_MAX)
				row_hits++;
		end
		left_hit = hit;
		if (re || fe) begin
			if (row_hits != 0) begin
				if (hit_rows < CNT_MAX)
					hit_rows++;
				kept_hits = row_hits;
			end
			row_hits = 0;
			cur_col = 0;
			left_hit = 1'b0;
			if (cur_row < ckrm_pkg::MAX_ROWS - 1)
				cur_row++;
		end else if (cur_col < ckrm_pkg::MAX_COLS - 1) begin
			cur_col++;
		end
		if (fe) begin
			s.last_row_matches = ckrm_pkg::CNT_W'(kept_hits);
			s.rows_matched = ckrm_pkg::CNT_W'(hit_rows);
			s.run_left_col = ckrm_pkg::POS_W'(run_col);
			s.run_top_row = ckrm_pkg::POS_W'(run_row);
			s.any_found = (hit_rows != 0);
			summary_q.push_back(s);
			cur_col = 0;
			cur_row = 0;
			left_hit = 1'b0;
			row_hits = 0;
			hit_rows = 0;
			kept_hits = 0;
			run_col = 0;
			run_row = 0;
		end
	endtask

	task automatic send_pixel(input logic [ckrm_pkg::CHAN_W-1:0] r, g, b,
		input logic re, fe);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pix_red <= r;
		pix_green <= g;
		pix_blue <= b;
		row_end <= re;
		frame_end <= fe;
		do @(posedge clk); while (!in_ready);
		measure_pixel(r, g, b, re, fe);
		pixels_sent++;
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (summary_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_color(input logic [ckrm_pkg::CHAN_W-1:0] r, g, b);
		ckrm_pkg::cfg_reg_t          regs[3];
		logic [ckrm_pkg::CHAN_W-1:0] vals[3];
		regs = '{ckrm_pkg::CFG_KEY_RED, ckrm_pkg::CFG_KEY_GREEN, ckrm_pkg::CFG_KEY_BLUE};
		vals = '{r, g, b};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (regs[i])
				ckrm_pkg::CFG_KEY_RED: key_r = vals[i];
				ckrm_pkg::CFG_KEY_GREEN: key_g = vals[i];
				ckrm_pkg::CFG_KEY_BLUE: key_b = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_random_key();
		write_key_color(ckrm_pkg::CHAN_W'($urandom_range(255)),
			ckrm_pkg::CHAN_W'($urandom_range(255)),
			ckrm_pkg::CHAN_W'($urandom_range(255)));
	endtask

	task automatic send_random_frame();
		int               rows;
		int               cols;
		int               x;
		int               y;
		int               sel;
		logic [PIX_W-1:0] c;
		rows = $urandom_range(1, 4);
		for (y = 0; y < rows; y++) begin
			cols = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (x = 0; x < cols; x++) begin
				sel = $urandom_range(99);
				c = {key_r, key_g, key_b};
				if (sel >= 65)
					c = PIX_W'($urandom);
				else if (sel >= 45)
					c[$urandom_range(PIX_W-1)] ^= 1'b1;
				if (x == cols - 1 && y == rows - 1)
					send_pixel(c[23:16], c[15:8], c[7:0], 1'($urandom_range(1)), 1'b1);
				else
					send_pixel(c[23:16], c[15:8], c[7:0], x == cols - 1, 1'b0);
			end
		end
		frames_sent++;
	endtask

	task automatic test_reset_key();
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd1, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
		pause_until_drained();
	endtask

	task automatic test_directed_frames();
		write_key_color(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
		send_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd254, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd254, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
		pause_until_drained();
	endtask

	// A long matching row broken by one miss near its end, then a tall frame of
	// one-pixel rows that all match.
	task automatic test_long_frames();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_random_key();
		for (int i = 0; i < LONG_LEN; i++)
			send_pixel(key_r, key_g, key_b, 1'b0, 1'b0);
		send_pixel(key_r ^ 8'h80, key_g, key_b, 1'b0, 1'b0);
		send_pixel(key_r, key_g, key_b, 1'b1, 1'b1);
		for (int i = 0; i < LONG_LEN; i++)
			send_pixel(key_r, key_g, key_b, 1'b1, i == LONG_LEN - 1);
		pause_until_drained();
	endtask

	task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
		int target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_random_key();
		target = pixels_sent + count;
		while (pixels_sent < target) begin
			send_random_frame();
			if (frames_sent % 16 == 0)
				pause_until_drained();
		end
		pause_until_drained();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_summary
		frame_summary_t want;
		if (arst_n && out_valid && out_ready) begin
			if (summary_q.size() == 0) begin
				$display("%0t: summary expected none, got %0d %0d %0d %0d %0d", $time,
					last_row_matches, rows_matched, run_left_col, run_top_row, any_found);
				mismatches++;
			end else begin
				want = summary_q.pop_front();
				check_field("last_row_matches", int'(want.last_row_matches),
					int'(last_row_matches));
				check_field("rows_matched", int'(want.rows_matched), int'(rows_matched));
				check_field("run_left_col", int'(want.run_left_col), int'(run_left_col));
				check_field("run_top_row", int'(want.run_top_row), int'(run_top_row));
				check_field("any_found", int'(want.any_found), int'(any_found));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_directed_frames();
		test_long_frames();
		test_random_stream(0, 0, 410);
		test_random_stream(59, 0, 410);
		test_random_stream(0, 59, 410);
		test_random_stream(19, 19, 410);
		pause_until_drained();
		if (mismatches == 0 && summary_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
